[sv/kdlp_pkg.sv]
`default_nettype none

package kdlp_pkg;

  // Key count and debounce depth.
  localparam int unsigned NUM_KEYS       = 4;
  localparam int unsigned STABLE_SAMPLES = 3;

  // Field widths fixed by the interface.
  localparam int unsigned PIN_W  = 4;
  localparam int unsigned MASK_W = 4;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned THR_W  = 16;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CNT_W  = $clog2(STABLE_SAMPLES + 1);

  // Threshold constants.
  localparam logic [THR_W-1:0] LONG_MIN_MS   = THR_W'(100);
  localparam logic [THR_W-1:0] HOLD_EXTRA_MS = THR_W'(500);
  localparam logic [THR_W-1:0] LONG_RESET_MS = THR_W'(1000);
  localparam logic [THR_W-1:0] HOLD_RESET_MS = THR_W'(3000);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_LONG = 1'b0,
    CFG_HOLD = 1'b1
  } cfg_reg_e;

  // Effective thresholds, shared by all lanes.
  typedef struct packed {
    logic [THR_W-1:0] long_ms;
    logic [THR_W-1:0] hold_ms;
  } thr_t;

  // What one lane found during one scan.
  typedef struct packed {
    logic short_evt;
    logic long_evt;
    logic hold_evt;
    logic pressed;
  } lane_evt_t;

  function automatic logic [THR_W-1:0] eff_long_f(input logic [THR_W-1:0] raw);
    eff_long_f = (raw < LONG_MIN_MS) ? LONG_MIN_MS : raw;
  endfunction

  function automatic logic [THR_W-1:0] eff_hold_f(input logic [THR_W-1:0] raw,
                                                  input logic [THR_W-1:0] lng);
    eff_hold_f = (raw < lng) ? THR_W'(lng + HOLD_EXTRA_MS) : raw;
  endfunction

endpackage

`default_nettype wire

[sv/kdlp_cfg.sv]
`default_nettype none

module kdlp_cfg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [0:0]                cfg_index_i,
  input  wire logic [kdlp_pkg::CFG_W-1:0] cfg_wdata_i,
  output kdlp_pkg::thr_t                 thr_o
);

  // Raw register values are kept so that the hold clamp sees the long register.
  logic [kdlp_pkg::THR_W-1:0] long_raw_q, long_raw_d;
  logic [kdlp_pkg::THR_W-1:0] hold_raw_q, hold_raw_d;
  kdlp_pkg::thr_t             thr_q, thr_d;
  logic [kdlp_pkg::THR_W-1:0] wdata;

  assign wdata = kdlp_pkg::THR_W'(cfg_wdata_i);

  always_comb begin
    long_raw_d = long_raw_q;
    hold_raw_d = hold_raw_q;
    if (cfg_we_i) begin
      case (kdlp_pkg::cfg_reg_e'(cfg_index_i))
        kdlp_pkg::CFG_LONG: long_raw_d = wdata;
        kdlp_pkg::CFG_HOLD: hold_raw_d = wdata;
        default: ;
      endcase
    end
    thr_d.long_ms = kdlp_pkg::eff_long_f(long_raw_d);
    thr_d.hold_ms = kdlp_pkg::eff_hold_f(hold_raw_d, thr_d.long_ms);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_raw_q    <= kdlp_pkg::LONG_RESET_MS;
      hold_raw_q    <= kdlp_pkg::HOLD_RESET_MS;
      thr_q.long_ms <= kdlp_pkg::LONG_RESET_MS;
      thr_q.hold_ms <= kdlp_pkg::HOLD_RESET_MS;
    end else begin
      long_raw_q <= long_raw_d;
      hold_raw_q <= hold_raw_d;
      thr_q      <= thr_d;
    end
  end

  assign thr_o = thr_q;

endmodule

`default_nettype wire

[sv/kdlp_lane.sv]
`default_nettype none

module kdlp_lane (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        raw_i,
  input  wire logic [kdlp_pkg::TIME_W-1:0] now_i,
  input  wire kdlp_pkg::thr_t              thr_i,
  output kdlp_pkg::lane_evt_t              evt_o
);

  localparam logic [kdlp_pkg::CNT_W-1:0] CntMax = kdlp_pkg::CNT_W'(kdlp_pkg::STABLE_SAMPLES);

  logic                        prev_q, prev_d;
  logic                        stable_q, stable_d;
  logic [kdlp_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [kdlp_pkg::TIME_W-1:0] start_q, start_d;
  logic                        long_sent_q, long_sent_d;
  logic                        hold_sent_q, hold_sent_d;
  logic [kdlp_pkg::TIME_W-1:0] held;
  logic                        reach_long, reach_hold;

  assign held       = now_i - start_q;
  assign reach_long = held >= kdlp_pkg::TIME_W'(thr_i.long_ms);
  assign reach_hold = held >= kdlp_pkg::TIME_W'(thr_i.hold_ms);

  always_comb begin
    prev_d      = raw_i;
    stable_d    = stable_q;
    start_d     = start_q;
    long_sent_d = long_sent_q;
    hold_sent_d = hold_sent_q;
    evt_o       = '0;

    if (raw_i == prev_q) begin
      cnt_d = (cnt_q < CntMax) ? cnt_q + 1'b1 : cnt_q;
    end else begin
      cnt_d = '0;
    end

    if (cnt_d >= CntMax) begin
      if (stable_q != raw_i) begin
        stable_d = raw_i;
        if (raw_i) begin
          start_d     = now_i;
          long_sent_d = 1'b0;
          hold_sent_d = 1'b0;
        end else if (!long_sent_q && !reach_long) begin
          evt_o.short_evt = 1'b1;
        end
      end else if (stable_q) begin
        if (!long_sent_q && reach_long) begin
          long_sent_d    = 1'b1;
          evt_o.long_evt = 1'b1;
        end
        if (!hold_sent_q && reach_hold) begin
          hold_sent_d    = 1'b1;
          evt_o.hold_evt = 1'b1;
        end
      end
    end
    evt_o.pressed = stable_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= 1'b0;
      stable_q    <= 1'b0;
      cnt_q       <= '0;
      long_sent_q <= 1'b0;
      hold_sent_q <= 1'b0;
    end else if (en_i) begin
      prev_q      <= prev_d;
      stable_q    <= stable_d;
      cnt_q       <= cnt_d;
      long_sent_q <= long_sent_d;
      hold_sent_q <= hold_sent_d;
    end
  end

  // The start time is only read after a stable press has written it.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      start_q <= start_d;
    end
  end

endmodule

`default_nettype wire

[sv/kdlp_merge.sv]
`default_nettype none

module kdlp_merge (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_fire_i,
  input  wire kdlp_pkg::lane_evt_t          evt_i [kdlp_pkg::NUM_KEYS],
  output logic                              full_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [kdlp_pkg::MASK_W-1:0]       short_mask_o,
  output logic [kdlp_pkg::MASK_W-1:0]       long_mask_o,
  output logic [kdlp_pkg::MASK_W-1:0]       hold_mask_o,
  output logic [kdlp_pkg::MASK_W-1:0]       pressed_mask_o
);

  typedef struct packed {
    logic [kdlp_pkg::MASK_W-1:0] sm;
    logic [kdlp_pkg::MASK_W-1:0] lm;
    logic [kdlp_pkg::MASK_W-1:0] hm;
    logic [kdlp_pkg::MASK_W-1:0] pm;
  } word_t;

  word_t merged;
  word_t out_q, skid_q;
  logic  out_vld_q, skid_vld_q;
  logic  out_fire, out_free;

  // Collect lane flags into masks; keys past the mask width are dropped.
  for (genvar i = 0; i < kdlp_pkg::MASK_W; i++) begin : g_bit
    if (i < kdlp_pkg::NUM_KEYS) begin : g_key
      assign merged.sm[i] = evt_i[i].short_evt;
      assign merged.lm[i] = evt_i[i].long_evt;
      assign merged.hm[i] = evt_i[i].hold_evt;
      assign merged.pm[i] = evt_i[i].pressed;
    end else begin : g_none
      assign merged.sm[i] = 1'b0;
      assign merged.lm[i] = 1'b0;
      assign merged.hm[i] = 1'b0;
      assign merged.pm[i] = 1'b0;
    end
  end

  assign out_fire = out_vld_q && !out_stall_i;
  assign out_free = !out_vld_q || out_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_vld_q  <= skid_vld_q || in_fire_i;
        skid_vld_q <= 1'b0;
      end else if (in_fire_i) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_vld_q ? skid_q : merged;
    end
    if (in_fire_i && !out_free) begin
      skid_q <= merged;
    end
  end

  assign full_o         = skid_vld_q;
  assign out_valid_o    = out_vld_q;
  assign short_mask_o   = out_q.sm;
  assign long_mask_o    = out_q.lm;
  assign hold_mask_o    = out_q.hm;
  assign pressed_mask_o = out_q.pm;

endmodule

`default_nettype wire

[sv/key_debounce_long_press_core.sv]
// Debounce and press-duration events for four active-low keys.
// Input channel: each word is one scan, the raw pin levels of the keys
// (0 means pressed) and a millisecond timestamp. It is taken at a rising
// edge where in_valid_i is high and in_stall_o is low.
// Output channel: one word per scan with SHORT, LONG and HOLD event masks and
// the stably pressed mask, handed over when out_valid_o is high and
// out_stall_i is low.
// Every key has its own lane that holds its debounce counter and press state;
// all lanes work on the same scan in the same cycle, and the merge stage
// packs their flags into masks. A result is registered in the output or skid
// register; one scan per cycle is sustained while the receiver does not stall,
// limited by the lane state update each scan must see from the scan before.
// A two-word output stage (output register plus skid register) lets a new
// scan be taken while a result waits; in_stall_o rises only when both words
// are occupied by a stalled receiver, and nothing is lost or repeated.
// Reset (rst_ni low) releases all keys, clears the counters and event flags,
// empties the output stage, loads thresholds of 1000/3000 ms. The user writes
// thresholds via cfg_we_i/cfg_index_i/cfg_wdata_i only in idle (not enforced).
`default_nettype none

module key_debounce_long_press_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [0:0]                   cfg_index_i,
  input  wire logic [kdlp_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [kdlp_pkg::PIN_W-1:0]   key_pins_n_i,
  input  wire logic [kdlp_pkg::TIME_W-1:0]  now_ms_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [kdlp_pkg::MASK_W-1:0]       short_mask_o,
  output logic [kdlp_pkg::MASK_W-1:0]       long_mask_o,
  output logic [kdlp_pkg::MASK_W-1:0]       hold_mask_o,
  output logic [kdlp_pkg::MASK_W-1:0]       pressed_mask_o
);

  kdlp_pkg::thr_t      thr;
  kdlp_pkg::lane_evt_t evt [kdlp_pkg::NUM_KEYS];
  logic                full;
  logic                in_fire;

  // The stall is registered state of the output stage, never the receiver's
  // stall itself, so the upstream side sees no combinational path.
  assign in_stall_o = full;
  assign in_fire    = in_valid_i && !full;

  // Effective thresholds are clamped when written, so lanes compare directly.
  kdlp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .thr_o       (thr)
  );

  for (genvar i = 0; i < kdlp_pkg::NUM_KEYS; i++) begin : g_lane
    logic raw;
    // Keys without a pin bit read as released.
    if (i < kdlp_pkg::PIN_W) begin : g_pin
      assign raw = !key_pins_n_i[i];
    end else begin : g_nopin
      assign raw = 1'b0;
    end

    kdlp_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (in_fire),
      .raw_i  (raw),
      .now_i  (now_ms_i),
      .thr_i  (thr),
      .evt_o  (evt[i])
    );
  end

  kdlp_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_fire_i      (in_fire),
    .evt_i          (evt),
    .full_o         (full),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .short_mask_o   (short_mask_o),
    .long_mask_o    (long_mask_o),
    .hold_mask_o    (hold_mask_o),
    .pressed_mask_o (pressed_mask_o)
  );

endmodule

`default_nettype wire
